### sv/sfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic for the sensor frame deframer.
// No dependencies; imported by every module of the block.
package sfd_pkg;

  localparam int CHANNELS_DEFAULT = 8;
  localparam int CHANNELS_MAX     = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_MARKER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER  = 1'b1;

  localparam logic [7:0] SYNC_MARKER_RESET = 8'h55;
  localparam logic [7:0] END_MARKER_RESET  = 8'h66;

  // frame positions counted from 1 after the sync byte
  localparam int POS_ID_HI  = 4;
  localparam int POS_ID_LO  = 5;
  localparam int POS_STATUS = 10;
  localparam int POS_READ0  = 11;

  localparam int TDATA_W = 72;
  localparam int TUSER_W = 2;

  typedef struct packed {
    logic signed [15:0] node_id;
    logic signed [15:0] parent_id;
    logic [7:0]         status;
    logic               complete;
  } frame_hdr_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] raw_reading;
    logic signed [15:0] temp_tenths;
    logic               sensor_open;
    logic signed [15:0] node_id;
    logic signed [15:0] parent_id;
    logic               frame_complete;
    logic               last;
  } result_t;

  // raw * 5 / 8, truncated toward zero
  function automatic logic signed [15:0] temp_from_raw(input logic signed [15:0] raw);
    logic signed [18:0] prod;
    prod = (19'(raw) <<< 2) + 19'(raw);
    if (prod < 0) begin
      prod = prod + 19'sd7;
    end
    return 16'(prod >>> 3);
  endfunction

endpackage

### sv/sfd_parser.sv
`timescale 1ns / 1ps
// Byte-stream side: sync hunt, frame position counter and field capture.
// Depends on sfd_pkg.
module sfd_parser
  import sfd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT,
  parameter int IDX_W    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          sync_marker,
  input  logic [7:0]          end_marker,
  input  logic                emit_busy,
  output logic                frame_done,
  output frame_hdr_t          hdr,
  output logic signed [15:0]  readings [CHANNELS]
);

  localparam int POS_READ_END = POS_READ0 + 2 * CHANNELS;
  localparam int POS_PAR_HI   = 12 + 2 * CHANNELS;
  localparam int POS_PAR_LO   = 13 + 2 * CHANNELS;
  localparam int POS_END      = 14 + 2 * CHANNELS;
  localparam int POS_W        = $clog2(POS_END + 1);

  logic              in_frame;
  logic [POS_W-1:0]  byte_position;
  logic [7:0]        high_byte_hold;
  logic [15:0]       frame_id;
  logic [7:0]        status_bits;
  logic [15:0]       frame_parent;

  logic              accept;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  read_ofs;
  logic              in_reads;
  logic              rd_we;
  logic [IDX_W-1:0]  rd_idx;

  assign in_ready = !(emit_busy && in_frame && (byte_position == POS_W'(POS_END - 1)));
  assign accept   = in_valid && in_ready;
  assign pos_next = byte_position + POS_W'(1);
  assign read_ofs = pos_next - POS_W'(POS_READ0);
  assign in_reads = (pos_next >= POS_W'(POS_READ0)) && (pos_next < POS_W'(POS_READ_END));
  assign rd_we    = accept && in_frame && in_reads && read_ofs[0];
  assign rd_idx   = IDX_W'(read_ofs >> 1);

  assign frame_done   = accept && in_frame && (pos_next == POS_W'(POS_END));
  assign hdr.node_id   = frame_id;
  assign hdr.parent_id = frame_parent;
  assign hdr.status    = status_bits;
  assign hdr.complete  = (in_byte == end_marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      byte_position  <= '0;
      high_byte_hold <= '0;
      frame_id       <= '0;
      status_bits    <= '0;
      frame_parent   <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (in_byte == sync_marker) begin
          in_frame      <= 1'b1;
          byte_position <= '0;
        end
      end else begin
        byte_position <= pos_next;
        if (pos_next == POS_W'(POS_ID_HI) || pos_next == POS_W'(POS_PAR_HI)) begin
          high_byte_hold <= in_byte;
        end else if (pos_next == POS_W'(POS_ID_LO)) begin
          frame_id <= {high_byte_hold, in_byte};
        end else if (pos_next == POS_W'(POS_PAR_LO)) begin
          frame_parent <= {high_byte_hold, in_byte};
        end else if (pos_next == POS_W'(POS_STATUS)) begin
          status_bits <= in_byte;
        end else if (in_reads && !read_ofs[0]) begin
          high_byte_hold <= in_byte;
        end else if (pos_next == POS_W'(POS_END)) begin
          in_frame      <= 1'b0;
          byte_position <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (rd_we && rd_idx == IDX_W'(i)) begin
        readings[i] <= {high_byte_hold, in_byte};
      end
    end
  end

endmodule

### sv/sfd_emitter.sv
`timescale 1ns / 1ps
// Result side: frame snapshot, channel counter and registered output stage.
// Depends on sfd_pkg.
module sfd_emitter
  import sfd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT,
  parameter int IDX_W    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_done,
  input  frame_hdr_t          hdr,
  input  logic signed [15:0]  readings [CHANNELS],
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_res
);

  localparam int EXT_W = (IDX_W > 3) ? IDX_W : 3;

  logic signed [15:0] snap_rd [CHANNELS];
  frame_hdr_t         snap_hdr;
  logic [IDX_W-1:0]   idx;
  logic [EXT_W-1:0]   idx_ext;
  logic               load_out;
  logic               idx_last;
  logic signed [15:0] raw_sel;
  result_t            res_next;

  assign load_out = busy && (!out_valid || out_ready);
  assign idx_last = (idx == IDX_W'(CHANNELS - 1));
  assign idx_ext  = EXT_W'(idx);
  assign raw_sel  = snap_rd[idx];

  always_comb begin
    res_next.channel        = idx_ext[2:0];
    res_next.raw_reading    = raw_sel;
    res_next.temp_tenths    = temp_from_raw(raw_sel);
    res_next.sensor_open    = ((idx_ext >> 3) == '0) && !snap_hdr.status[idx_ext[2:0]];
    res_next.node_id        = snap_hdr.node_id;
    res_next.parent_id      = snap_hdr.parent_id;
    res_next.frame_complete = snap_hdr.complete;
    res_next.last           = idx_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (frame_done) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load_out) begin
        idx <= idx_last ? '0 : idx + IDX_W'(1);
        if (idx_last) begin
          busy <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      snap_rd  <= readings;
      snap_hdr <= hdr;
    end
    if (load_out) begin
      out_res <= res_next;
    end
  end

endmodule

### sv/sensor_frame_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the sensor frame deframer: configuration registers and stream ports.
// Depends on sfd_pkg, sfd_parser and sfd_emitter.

// Takes one stream byte per cycle while s_tready is high. Bytes are dropped until
// the sync marker is seen; the frame that follows is 14 + 2*CHANNELS bytes long,
// and its end byte copies the captured fields into a snapshot and starts CHANNELS
// results, one per cycle while m_tready is high, channel 0 first, tlast on the final one.
// The end byte of the next frame is held off (s_tready low) only if the
// previous frame's results are still being delivered from the snapshot.
// The end byte sets busy; the first result is then loaded into the output register.
module sensor_frame_deframer_core
  import sfd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] rx_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata,   // channel, raw_reading, temp_tenths, node_id,
                                            // parent_id, zero pad
  output logic [TUSER_W-1:0]     m_tuser,   // sensor_open, frame_complete
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]         sync_marker;
  logic [7:0]         end_marker;
  logic               emit_busy;
  logic               frame_done;
  frame_hdr_t         hdr;
  logic signed [15:0] readings [CHANNELS];
  result_t            out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_marker <= SYNC_MARKER_RESET;
      end_marker  <= END_MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_MARKER: sync_marker <= cfg_data;
        REG_END_MARKER:  end_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  sfd_parser #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .sync_marker (sync_marker),
    .end_marker  (end_marker),
    .emit_busy   (emit_busy),
    .frame_done  (frame_done),
    .hdr         (hdr),
    .readings    (readings)
  );

  sfd_emitter #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .frame_done (frame_done),
    .hdr        (hdr),
    .readings   (readings),
    .busy       (emit_busy),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = {5'b0, out_res.parent_id, out_res.node_id, out_res.temp_tenths,
                    out_res.raw_reading, out_res.channel};
  assign m_tuser = {out_res.frame_complete, out_res.sensor_open};
  assign m_tlast = out_res.last;

`ifndef ASSERT_OFF
  a_snapshot_free: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> !emit_busy)
    else $error("snapshot overwritten while results pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> emit_busy)
    else $error("input stalled with no results pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("result changed while waiting for m_tready");
`endif

endmodule
